[hw/rtl/encoder_count_unwrap_odometry_defines.svh]
// ----------------------------------------------------------------------------
// Encoder odometry assertion macros
// Shared concurrent check forms, clocked on clk_i and off while in reset.
// ----------------------------------------------------------------------------
`ifndef ENCODER_COUNT_UNWRAP_ODOMETRY_DEFINES_SVH
`define ENCODER_COUNT_UNWRAP_ODOMETRY_DEFINES_SVH

// Same-cycle implication.
`define ECUO_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ecuo check failed");

// Next-cycle implication.
`define ECUO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ecuo check failed");

`endif

[hw/rtl/ecuo_pkg.sv]
// ----------------------------------------------------------------------------
// Encoder odometry package
// Shared types, register indexes and scaling constants.
// ----------------------------------------------------------------------------
package ecuo_pkg;

  // Default accumulator width.
  localparam int unsigned AccumWidthDef = 48;
  // Depth of the queue between front and back end.
  localparam int unsigned QueueDepth    = 2;

  // Beat widths.
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 360;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegMode      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegThreshold = 3'd1;
  localparam logic [CfgIdxW-1:0] RegEdgeMult  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGear      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLines     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRadius    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPeriod    = 3'd6;

  // Scaling constants.
  localparam logic [31:0] TwoPiQ29 = 32'd3373259426;
  localparam logic [63:0] MulRot   = 64'd1 << 24;
  localparam logic [63:0] MulAngle = 64'd360 << 24;
  localparam logic [63:0] MulRpm   = 64'd60000 << 24;
  localparam logic signed [47:0] OutMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] OutMin = 48'sh8000_0000_0000;

  // Settings used by the back end.
  typedef struct packed {
    logic [2:0]  edge_multiple;
    logic [15:0] gear_ratio_q8;
    logic [15:0] lines_per_rev;
    logic [15:0] wheel_radius_q8;
    logic [15:0] sample_period_ms;
  } scale_cfg_t;

  // One classified sample passed from front to back.
  typedef struct packed {
    logic signed [63:0] acc;
    logic signed [47:0] total;
    logic signed [31:0] wrap;
    logic signed [32:0] step;
    logic               down;
    logic               clr;
  } item_t;

  // Result beat, lowest field last.
  typedef struct packed {
    logic [4:0]         pad;
    logic               clear_counter;
    logic signed [47:0] linear_speed_q16;
    logic signed [47:0] speed_rpm_q16;
    logic signed [47:0] distance_q16;
    logic signed [47:0] angle_q16;
    logic signed [47:0] rotations_q16;
    logic signed [31:0] wrap_count;
    logic signed [47:0] total_count;
    logic signed [32:0] step_count;
    logic               direction;
  } result_t;

endpackage

[hw/rtl/encoder_count_unwrap_odometry.sv]
// ----------------------------------------------------------------------------
// Encoder count unwrap and odometry
// Top level: configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
// Each input beat is one timer sample; each gives exactly one result beat.
// The front end takes a sample every cycle while its queue has room, so the
// count, wrap tally and total are settled at once. The back end works out
// the five Q.16 values in turn on one shared 32x32 multiplier and a restoring
// divider that yields one quotient bit per cycle: five setup products, then
// per value the partial products, a range check, the division and a rounding
// step, with no division or rounding when a value saturates or its divisor is
// zero. That divider sets the sustained rate. The user must give registers new
// values only while no sample is in flight; the block does not enforce it.
module encoder_count_unwrap_odometry #(
  parameter int unsigned ACCUM_WIDTH = ecuo_pkg::AccumWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ecuo_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ecuo_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // counter_value[31:0], counting_down[32], zero pad[39:33]
  input  logic [ecuo_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // direction[0], step_count[33:1], total_count[81:34], wrap_count[113:82],
  // rotations_q16[161:114], angle_q16[209:162], distance_q16[257:210],
  // speed_rpm_q16[305:258], linear_speed_q16[353:306], clear_counter[354],
  // zero pad[359:355]
  output logic [ecuo_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import ecuo_pkg::*;

  logic        mode_q;
  logic [30:0] thr_q;
  scale_cfg_t  cfg_q;
  logic        push, full, pop, empty;
  item_t       item_in, item_out;
  result_t     result;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q                 <= 1'b1;
      thr_q                  <= 31'd30000;
      cfg_q.edge_multiple    <= 3'd4;
      cfg_q.gear_ratio_q8    <= 16'd7680;
      cfg_q.lines_per_rev    <= 16'd13;
      cfg_q.wheel_radius_q8  <= 16'd4864;
      cfg_q.sample_period_ms <= 16'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegMode:      mode_q                 <= cfg_data_i[0];
        RegThreshold: thr_q                  <= cfg_data_i;
        RegEdgeMult:  cfg_q.edge_multiple    <= cfg_data_i[2:0];
        RegGear:      cfg_q.gear_ratio_q8    <= cfg_data_i[15:0];
        RegLines:     cfg_q.lines_per_rev    <= cfg_data_i[15:0];
        RegRadius:    cfg_q.wheel_radius_q8  <= cfg_data_i[15:0];
        RegPeriod:    cfg_q.sample_period_ms <= cfg_data_i[15:0];
        default:      ;
      endcase
    end
  end

  ecuo_front #(
    .AccumWidth(ACCUM_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_q),
    .jump_threshold_i (thr_q),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .counter_value_i  (s_axis_tdata_i[31:0]),
    .counting_down_i  (s_axis_tdata_i[32]),
    .push_o           (push),
    .item_o           (item_in),
    .full_i           (full)
  );

  ecuo_fifo #(
    .Width($bits(item_t)),
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (item_out),
    .empty_o (empty)
  );

  ecuo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .item_i      (item_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (result)
  );

  assign m_axis_tdata_o = result;

endmodule

[hw/rtl/ecuo_fifo.sv]
// ----------------------------------------------------------------------------
// Encoder odometry queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "encoder_count_unwrap_odometry_defines.svh"

module ecuo_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  // Depth must be a power of two so that the pointers wrap naturally; the module does not check this.
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ECUO_ASSERT(a_count_in_range, 1'b1, count_q <= CntW'(Depth))

endmodule

[hw/rtl/ecuo_front.sv]
// ----------------------------------------------------------------------------
// Encoder odometry front end
// Takes counter samples, unwraps the step, keeps the overflow tally and the
// saturating total, and pushes one classified item per sample to the queue.
// ----------------------------------------------------------------------------
module ecuo_front #(
  parameter int unsigned AccumWidth = ecuo_pkg::AccumWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  mode_i,
  input  logic [30:0]           jump_threshold_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [31:0]           counter_value_i,
  input  logic                  counting_down_i,
  output logic                  push_o,
  output ecuo_pkg::item_t       item_o,
  input  logic                  full_i
);
  import ecuo_pkg::*;

  localparam logic signed [33:0] SpanShort = 34'sh0_0001_0000;
  localparam logic signed [33:0] SpanLong  = 34'sh1_0000_0000;

  // Persistent state.
  logic [31:0]                  prev_q, prev_d;
  logic [31:0]                  tally_q, tally_d;
  logic signed [AccumWidth-1:0] acc_q, acc_d;

  // Stage one holding register.
  logic               s1_valid_q, s1_valid_d;
  logic signed [32:0] s1_step_q, s1_step_d;
  logic [31:0]        s1_wrap_q, s1_wrap_d;
  logic               s1_down_q, s1_down_d;
  logic               s1_clr_q, s1_clr_d;

  logic                         accept;
  logic signed [33:0]           diff, thr, span, step_w;
  logic signed [AccumWidth:0]   sum;
  logic signed [63:0]           acc64;

  assign push_o     = s1_valid_q && !full_i;
  assign in_ready_o = !s1_valid_q || push_o;
  assign accept     = in_valid_i && in_ready_o;

  // Step classification: clear mode or unwrapped difference.
  always_comb begin
    diff    = $signed({2'b00, counter_value_i}) - $signed({2'b00, prev_q});
    thr     = $signed({3'b000, jump_threshold_i});
    span    = (|prev_q[31:16] || |counter_value_i[31:16]) ? SpanLong : SpanShort;
    step_w  = diff;
    tally_d = tally_q;
    prev_d  = prev_q;
    if (!mode_i) begin
      step_w = 34'($signed(counter_value_i[15:0]));
    end else if (diff > thr) begin
      step_w  = diff - span;
      tally_d = tally_q - 32'd1;
    end else if (diff < -thr) begin
      step_w  = diff + span;
      tally_d = tally_q + 32'd1;
    end
    if (accept) begin
      prev_d = mode_i ? counter_value_i : 32'd0;
    end else begin
      tally_d = tally_q;
    end
    s1_valid_d = accept ? 1'b1 : (push_o ? 1'b0 : s1_valid_q);
    s1_step_d  = accept ? step_w[32:0] : s1_step_q;
    s1_wrap_d  = accept ? tally_d : s1_wrap_q;
    s1_down_d  = accept ? counting_down_i : s1_down_q;
    s1_clr_d   = accept ? !mode_i : s1_clr_q;
  end

  // Saturating accumulation, done as the item enters the queue.
  always_comb begin
    sum = $signed({acc_q[AccumWidth-1], acc_q}) + (AccumWidth + 1)'(s1_step_q);
    if (sum[AccumWidth] != sum[AccumWidth-1]) begin
      acc_d = sum[AccumWidth] ? {1'b1, {(AccumWidth-1){1'b0}}}
                              : {1'b0, {(AccumWidth-1){1'b1}}};
    end else begin
      acc_d = sum[AccumWidth-1:0];
    end
    if (!push_o) begin
      acc_d = acc_q;
    end
    acc64 = 64'(acc_d);
    item_o.acc  = acc64;
    item_o.step = s1_step_q;
    item_o.wrap = s1_wrap_q;
    item_o.down = s1_down_q;
    item_o.clr  = s1_clr_q;
    if (acc64 > 64'(OutMax)) begin
      item_o.total = OutMax;
    end else if (acc64 < 64'(OutMin)) begin
      item_o.total = OutMin;
    end else begin
      item_o.total = acc64[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      tally_q    <= '0;
      acc_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      prev_q     <= prev_d;
      tally_q    <= tally_d;
      acc_q      <= acc_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_step_q <= s1_step_d;
    s1_wrap_q <= s1_wrap_d;
    s1_down_q <= s1_down_d;
    s1_clr_q  <= s1_clr_d;
  end

endmodule

[hw/rtl/ecuo_back.sv]
// ----------------------------------------------------------------------------
// Encoder odometry back end
// Scales one item into the five Q.16 results with a shared 32x32 multiplier
// and a one-bit-per-cycle divider, then holds the result beat for output.
// ----------------------------------------------------------------------------
`include "encoder_count_unwrap_odometry_defines.svh"

module ecuo_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ecuo_pkg::scale_cfg_t cfg_i,
  input  logic                 empty_i,
  input  ecuo_pkg::item_t      item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ecuo_pkg::result_t    out_o
);
  import ecuo_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_RND   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  localparam logic [2:0] OpRot   = 3'd0;
  localparam logic [2:0] OpAngle = 3'd1;
  localparam logic [2:0] OpDist  = 3'd2;
  localparam logic [2:0] OpRpm   = 3'd3;
  localparam logic [2:0] OpLin   = 3'd4;

  state_e             state_q, state_d;
  logic [2:0]         op_q, op_d;
  logic [5:0]         cnt_q, cnt_d;
  item_t              item_q, item_d;
  logic [18:0]        t1_q, t1_d;
  logic [34:0]        dv_q, dv_d;
  logic [50:0]        dp_q, dp_d;
  logic [47:0]        mdist_q, mdist_d;
  logic [57:0]        mlin_q, mlin_d;
  logic [127:0]       prod_q, prod_d;
  logic [63:0]        rem_q, rem_d, quo_q, quo_d;
  logic signed [47:0] res_q [5];
  logic signed [47:0] res_d [5];
  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;

  logic signed [63:0] a_s;
  logic               neg, adv;
  logic [63:0]        amag, mul, dvs, quo_r;
  logic [63:0]        pp;
  logic [6:0]         shamt;
  logic [64:0]        rs;
  logic signed [47:0] val;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign pop_o       = (state_q == S_IDLE) && !empty_i;

  // Operand selection for the current scaling operation.
  always_comb begin
    a_s  = (op_q < OpRpm) ? item_q.acc : 64'(item_q.step);
    neg  = a_s[63];
    amag = neg ? 64'(-a_s) : 64'(a_s);
    case (op_q)
      OpRot:   begin mul = MulRot;         dvs = 64'(dv_q);         end
      OpAngle: begin mul = MulAngle;       dvs = 64'(dv_q);         end
      OpDist:  begin mul = 64'(mdist_q);   dvs = 64'(dv_q) << 13;   end
      OpRpm:   begin mul = MulRpm;         dvs = 64'(dp_q);         end
      default: begin mul = 64'(mlin_q);    dvs = 64'(dp_q) << 13;   end
    endcase
    pp    = 64'(cnt_q[0] ? amag[63:32] : amag[31:0]) *
            64'(cnt_q[1] ? mul[63:32] : mul[31:0]);
    shamt = 7'({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]}) << 5;
    rs    = {rem_q, prod_q[63]};
    quo_r = quo_q + 64'(rem_q >= (dvs - rem_q));
  end

  // Sequencer and datapath.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    item_d      = item_q;
    t1_d        = t1_q;
    dv_d        = dv_q;
    dp_d        = dp_q;
    mdist_d     = mdist_q;
    mlin_d      = mlin_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    adv         = 1'b0;
    val         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          item_d  = item_i;
          cnt_d   = '0;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        // One product per cycle for the divisors and the radius factors.
        cnt_d = cnt_q + 6'd1;
        case (cnt_q[2:0])
          3'd0:    t1_d    = 19'(cfg_i.edge_multiple) * 19'(cfg_i.gear_ratio_q8);
          3'd1:    dv_d    = 35'(t1_q) * 35'(cfg_i.lines_per_rev);
          3'd2:    dp_d    = 51'(dv_q) * 51'(cfg_i.sample_period_ms);
          3'd3:    mdist_d = 48'(TwoPiQ29) * 48'(cfg_i.wheel_radius_q8);
          default: begin
            mlin_d  = 58'(mdist_q) * 58'(10'd1000);
            op_d    = OpRot;
            cnt_d   = '0;
            prod_d  = '0;
            state_d = S_MUL;
          end
        endcase
      end
      S_MUL: begin
        prod_d = prod_q + (128'(pp) << shamt);
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'd3) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (dvs == '0) begin
          val = '0;
          adv = 1'b1;
        end else if (prod_q[127:64] >= dvs) begin
          val = neg ? OutMin : OutMax;
          adv = 1'b1;
        end else begin
          rem_d   = prod_q[127:64];
          quo_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        prod_d[63:0] = {prod_q[62:0], 1'b0};
        if (rs >= {1'b0, dvs}) begin
          rem_d = 64'(rs - {1'b0, dvs});
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rs[63:0];
          quo_d = {quo_q[62:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        // Round half away from zero, then saturate to the field range.
        if (neg) begin
          val = (quo_r > 64'd140737488355328) ? OutMin : 48'(-quo_r);
        end else begin
          val = (quo_r > 64'(OutMax)) ? OutMax : quo_r[47:0];
        end
        adv = 1'b1;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_d.pad              = '0;
          out_d.clear_counter    = item_q.clr;
          out_d.linear_speed_q16 = res_q[OpLin];
          out_d.speed_rpm_q16    = res_q[OpRpm];
          out_d.distance_q16     = res_q[OpDist];
          out_d.angle_q16        = res_q[OpAngle];
          out_d.rotations_q16    = res_q[OpRot];
          out_d.wrap_count       = item_q.wrap;
          out_d.total_count      = item_q.total;
          out_d.step_count       = item_q.step;
          out_d.direction        = item_q.down;
          state_d                = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // Store the finished operation and move to the next one.
    if (adv) begin
      res_d[op_q] = val;
      cnt_d       = '0;
      prod_d      = '0;
      if (op_q == OpLin) begin
        state_d = S_DONE;
      end else begin
        op_d    = op_q + 3'd1;
        state_d = S_MUL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OpRot;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    t1_q    <= t1_d;
    dv_q    <= dv_d;
    dp_q    <= dp_d;
    mdist_q <= mdist_d;
    mlin_q  <= mlin_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  `ECUO_ASSERT(a_rem_below_divisor, state_q == S_DIV, rem_q < dvs)
  `ECUO_ASSERT(a_done_after_last_op, state_q == S_DONE, op_q == OpLin)
  `ECUO_ASSERT_NEXT(a_pop_starts_setup, pop_o, state_q == S_SETUP)

endmodule

[tb/sv/encoder_count_unwrap_odometry_tb.sv]
// ----------------------------------------------------------------------------
// Encoder count unwrap and odometry testbench
// Sends timer samples through the stream port under random idling on both
// sides and checks every result beat against a cycle-free predictor of the
// count unwrapping, accumulation and Q.16 odometry scaling.
// ----------------------------------------------------------------------------
module encoder_count_unwrap_odometry_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ecuo_pkg::*;

  // Index past the register list; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  // Cycles the back end may still need after the last beat.
  localparam int SettleCycles = 450;
  localparam logic [63:0] AccMax = (64'd1 << 47) - 1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;

  always #5 clk_i = ~clk_i;

  encoder_count_unwrap_odometry dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // Register copies and predictor state.
  logic        sh_mode;
  logic [30:0] sh_threshold;
  logic [2:0]  sh_edge_mult;
  logic [15:0] sh_gear, sh_lines, sh_radius, sh_period;
  logic [31:0] last_count;
  logic signed [63:0] odo_total;
  logic [31:0] wrap_tally;

  result_t expected_q[$];
  int failures = 0;
  int n_samples = 0;
  int n_results = 0;
  int n_settings = 0;
  bit burst = 1'b0;

  // round(a * m / d), ties away from zero, saturated to 48 bits signed.
  function automatic logic signed [47:0] scale_q16(logic signed [63:0] a,
                                                   logic [63:0] m, logic [63:0] d);
    logic neg;
    logic [63:0] ua;
    logic [127:0] prod, quo, rem;
    if (d == 0) return '0;
    neg = a < 0;
    ua = neg ? -a : a;
    prod = {64'd0, ua} * {64'd0, m};
    if (prod[127:64] >= d) return neg ? OutMin : OutMax;
    quo = prod / d;
    rem = prod % d;
    if (rem >= {64'd0, d} - rem) quo = quo + 1;
    if (neg) return (quo > AccMax + 1) ? OutMin : -quo[47:0];
    return (quo > AccMax) ? OutMax : quo[47:0];
  endfunction

  // Advances the odometry state by one sample and forms its result beat.
  function automatic result_t odometry_update(logic [31:0] now, logic down);
    result_t r;
    logic signed [63:0] step, span, thr;
    logic [63:0] cpr, cpr_t;
    if (sh_mode == 1'b0) begin
      step = {{48{now[15]}}, now[15:0]};
      last_count = '0;
    end else begin
      thr = {33'd0, sh_threshold};
      span = (last_count > 32'd65535 || now > 32'd65535) ? 64'sd4294967296 : 64'sd65536;
      step = $signed({32'd0, now}) - $signed({32'd0, last_count});
      if (step > thr) begin
        wrap_tally = wrap_tally - 1;
        step = step - span;
      end else if (step < -thr) begin
        wrap_tally = wrap_tally + 1;
        step = step + span;
      end
      last_count = now;
    end
    if (step > 0 && odo_total > $signed(AccMax) - step) odo_total = AccMax;
    else if (step < 0 && odo_total < -$signed(AccMax) - 1 - step)
      odo_total = -$signed(AccMax) - 1;
    else odo_total = odo_total + step;

    cpr = 64'(sh_edge_mult) * 64'(sh_gear) * 64'(sh_lines);
    cpr_t = cpr * 64'(sh_period);
    r = '0;
    r.direction        = down;
    r.step_count       = step[32:0];
    r.total_count      = odo_total[47:0];
    r.wrap_count       = wrap_tally;
    r.rotations_q16    = scale_q16(odo_total, MulRot, cpr);
    r.angle_q16        = scale_q16(odo_total, MulAngle, cpr);
    r.distance_q16     = scale_q16(odo_total, 64'(TwoPiQ29) * 64'(sh_radius), cpr << 13);
    r.speed_rpm_q16    = scale_q16(step, MulRpm, cpr_t);
    r.linear_speed_q16 = scale_q16(step, 64'd1000 * 64'(TwoPiQ29) * 64'(sh_radius),
                                   cpr_t << 13);
    r.clear_counter    = ~sh_mode;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      failures++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Result side: compares each beat and draws its own stalls.
  int stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    result_t act, exp_r;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        act = result_t'(m_data);
        n_results++;
        if (expected_q.size() == 0) begin
          failures++;
          $display("%0t: result beat with nothing expected, actual %h", $time, m_data);
        end else begin
          exp_r = expected_q.pop_front();
          check_field("direction", 64'(exp_r.direction), 64'(act.direction));
          check_field("step_count", 64'(exp_r.step_count), 64'(act.step_count));
          check_field("total_count", 64'(exp_r.total_count), 64'(act.total_count));
          check_field("wrap_count", 64'(exp_r.wrap_count), 64'(act.wrap_count));
          check_field("rotations_q16", 64'(exp_r.rotations_q16), 64'(act.rotations_q16));
          check_field("angle_q16", 64'(exp_r.angle_q16), 64'(act.angle_q16));
          check_field("distance_q16", 64'(exp_r.distance_q16), 64'(act.distance_q16));
          check_field("speed_rpm_q16", 64'(exp_r.speed_rpm_q16), 64'(act.speed_rpm_q16));
          check_field("linear_speed_q16", 64'(exp_r.linear_speed_q16),
                      64'(act.linear_speed_q16));
          check_field("clear_counter", 64'(exp_r.clear_counter), 64'(act.clear_counter));
        end
        stall = burst ? 0 : $urandom_range(0, 5);
        m_ready <= (stall == 0);
      end else if (stall > 0) begin
        stall--;
        m_ready <= (stall == 0);
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Register write; the enable is lowered by the next sample or wait.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CfgDataW-1:0];
    @(posedge clk_i);
    case (idx)
      RegMode:      sh_mode = val[0];
      RegThreshold: sh_threshold = val[30:0];
      RegEdgeMult:  sh_edge_mult = val[2:0];
      RegGear:      sh_gear = val[15:0];
      RegLines:     sh_lines = val[15:0];
      RegRadius:    sh_radius = val[15:0];
      RegPeriod:    sh_period = val[15:0];
      default: ;
    endcase
  endtask

  // Holds off the sender until every result has come and the block is quiet.
  task automatic drain();
    s_valid <= 1'b0;
    cfg_we <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_sample(logic [31:0] val, logic down, output result_t r);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    cfg_we <= 1'b0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {7'd0, down, val};
    do @(posedge clk_i); while (!s_ready);
    r = odometry_update(val, down);
    expected_q.push_back(r);
    n_samples++;
  endtask

  task automatic write_settings(logic m, logic [30:0] thr, logic [2:0] em, logic [15:0] g,
                                logic [15:0] l, logic [15:0] rad, logic [15:0] per);
    drain();
    write_reg(RegMode, m);
    write_reg(RegThreshold, thr);
    write_reg(RegEdgeMult, em);
    write_reg(RegGear, g);
    write_reg(RegLines, l);
    write_reg(RegRadius, rad);
    write_reg(RegPeriod, per);
    n_settings++;
  endtask

  // Directed rows: a register write or a sample, some with typed step and wrap.
  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [63:0] val;
    logic        down;
    bit          has_exp;
    logic [32:0] exp_step;
    logic [31:0] exp_wrap;
  } row_t;

  row_t rows[] = '{
    // Reset settings, free-running counter.
    '{0, 0, 64'd0,          0, 1, 33'd0,                32'd0},
    '{0, 0, 64'd30000,      0, 1, 33'd30000,            32'd0},
    '{0, 0, 64'd60001,      0, 1, -33'sd35535,          32'hFFFF_FFFF},
    '{0, 0, 64'd65535,      1, 1, 33'd5534,             32'hFFFF_FFFF},
    '{0, 0, 64'd0,          1, 1, 33'd1,                32'd0},
    '{0, 0, 64'hFFFF_FFFF,  1, 1, -33'sd1,              32'hFFFF_FFFF},
    '{0, 0, 64'h8000_0000,  0, 1, 33'd2147483649,       32'd0},
    '{0, 0, 64'd0,          0, 1, 33'd2147483648,       32'd1},
    // Clear mode: low half is the signed step.
    '{1, RegMode, 64'd0,    0, 0, 0, 0},
    '{0, 0, 64'h0000_8000,  1, 1, -33'sd32768,          32'd1},
    '{0, 0, 64'hFFFF_7FFF,  0, 1, 33'd32767,            32'd1},
    '{0, 0, 64'hABCD_0000,  0, 1, 33'd0,                32'd1},
    // Write past the register list is dropped.
    '{1, RegUnused, 64'd1,  0, 0, 0, 0},
    '{0, 0, 64'h0000_0005,  0, 1, 33'd5,                32'd1},
    // Threshold zero: every nonzero difference wraps.
    '{1, RegMode, 64'd1,    0, 0, 0, 0},
    '{1, RegThreshold, 64'd0, 0, 0, 0, 0},
    '{0, 0, 64'd2,          0, 1, -33'sd65534,          32'd0},
    '{0, 0, 64'd2,          0, 1, 33'd0,                32'd0},
    // Zero divisors give zero scaled outputs.
    '{1, RegEdgeMult, 64'd0, 0, 0, 0, 0},
    '{1, RegPeriod, 64'd0,  0, 0, 0, 0},
    '{0, 0, 64'd1,          1, 0, 0, 0},
    '{1, RegThreshold, 64'h7FFF_FFFF, 0, 0, 0, 0},
    '{0, 0, 64'hFFFF_FFFF,  1, 0, 0, 0},
    '{0, 0, 64'd0,          0, 0, 0, 0}
  };

  initial begin
    result_t r;
    logic [31:0] v;
    logic signed [31:0] delta;
    int sel;
    sh_mode = 1'b1;
    sh_threshold = 31'd30000;
    sh_edge_mult = 3'd4;
    sh_gear = 16'd7680;
    sh_lines = 16'd13;
    sh_radius = 16'd4864;
    sh_period = 16'd10;
    last_count = '0;
    odo_total = '0;
    wrap_tally = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_sample(rows[i].val[31:0], rows[i].down, r);
        if (rows[i].has_exp && (r.step_count !== rows[i].exp_step ||
                                r.wrap_count !== rows[i].exp_wrap)) begin
          failures++;
          $display("%0t: directed row %0d, expected step %h wrap %h, actual %h %h",
                   $time, i, rows[i].exp_step, rows[i].exp_wrap, r.step_count,
                   r.wrap_count);
        end
      end
    end

    // Random phases, the first two at the register extremes.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: write_settings(1'b1, 31'd1, 3'd1, 16'd256, 16'd1, 16'd1, 16'd1);
        1: write_settings(1'b1, 31'h7FFF_FFFF, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: write_settings(1'b0, 31'($urandom()), 3'd4, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
        default: write_settings($urandom_range(0, 3) != 0, $urandom_range(1, 70000),
                                $urandom_range(1, 4), $urandom_range(256, 65535),
                                $urandom_range(1, 65535), $urandom_range(1, 65535),
                                $urandom_range(1, 65535));
      endcase
      burst = (ph % 3 == 2);
      for (int k = 0; k < 103; k++) begin
        if (ph == 4 && k == 50) drain();
        sel = $urandom_range(0, 9);
        delta = $signed($urandom_range(0, 8000)) - 4000;
        if (sel < 4) v = (last_count + delta) & 32'h0000_FFFF;
        else if (sel < 6) v = last_count + delta;
        else if (sel < 8) v = $urandom_range(0, 65535);
        else v = $urandom();
        send_sample(v, $urandom_range(0, 1), r);
      end
    end

    drain();
    $display("Covered %0d samples over %0d register settings, %0d result beats checked.",
             n_samples, n_settings, n_results);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit, well above the slowest correct run.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
